@@ rtl/nalv_pkg.sv @@
`timescale 1ns / 1ps

package nalv_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int BYTE_BITS       = 8;
   localparam int LEN_CFG_BITS    = 3;
   localparam int LEN_BITS        = 32;
   localparam int SEEN_BITS       = 3;
   localparam int STATUS_BITS     = 3;
   localparam int KNOWN_OUT_BITS  = 16;
   localparam int RSP_DATA_BITS   = 24;
   localparam int NAL_TYPE_BITS   = 5;

   localparam logic [LEN_CFG_BITS-1:0] LEN_BYTES_RESET = 3'd4;
   localparam logic [LEN_CFG_BITS-1:0] LEN_BYTES_MAX   = 3'd4;

   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ZERO_LEN = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERRUN  = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_KNOWN = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_TRAILING = 3'd4;

   localparam logic [NAL_TYPE_BITS-1:0] NAL_SLICE = 5'd1;
   localparam logic [NAL_TYPE_BITS-1:0] NAL_IDR   = 5'd5;
   localparam logic [NAL_TYPE_BITS-1:0] NAL_SEI   = 5'd6;
   localparam logic [NAL_TYPE_BITS-1:0] NAL_SPS   = 5'd7;
   localparam logic [NAL_TYPE_BITS-1:0] NAL_PPS   = 5'd8;
   localparam logic [NAL_TYPE_BITS-1:0] NAL_AUD   = 5'd9;

   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
      logic                 last_byte;
   } beat_type;

   typedef struct packed {
      logic [KNOWN_OUT_BITS-1:0] known_units;
      logic [STATUS_BITS-1:0]    status;
      logic                      sample_ok;
   } verdict_type;

   function automatic logic nal_type_known(input logic [BYTE_BITS-1:0] b);
      logic [NAL_TYPE_BITS-1:0] t;
      t = b[NAL_TYPE_BITS-1:0];
      return (t == NAL_SLICE) || (t == NAL_IDR) || (t == NAL_SEI) ||
             (t == NAL_SPS) || (t == NAL_PPS) || (t == NAL_AUD);
   endfunction

endpackage

@@ rtl/nalv_in_stage.sv @@
`timescale 1ns / 1ps

module nalv_in_stage
   import nalv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  beat_type in_beat,
   output logic     out_valid,
   input  logic     out_pop,
   output beat_type out_beat
);

   logic     valid_ff;
   logic     valid_in;
   beat_type beat_ff;

   assign in_ready  = !valid_ff || out_pop;
   assign valid_in  = (in_valid && in_ready) || (valid_ff && !out_pop);
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         beat_ff <= in_beat;
      end
   end

endmodule

@@ rtl/nalv_parser.sv @@
`timescale 1ns / 1ps

module nalv_parser
   import nalv_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [LEN_CFG_BITS-1:0] len_bytes,
   input  logic                    beat_valid,
   input  beat_type                beat,
   input  logic                    result_space,
   output logic                    beat_pop,
   output logic                    result_valid,
   output verdict_type             result
);

   typedef enum logic [1:0] {
      PH_PREFIX = 2'd0,
      PH_HEADER = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_ZERO    = 2'd1,
      ERR_OVERRUN = 2'd2
   } err_type;

   localparam logic [COUNT_BITS-1:0] COUNT_CAP = '1;

   phase_type              phase_ff,  phase_in;
   logic [SEEN_BITS-1:0]   seen_ff,   seen_in;
   logic [LEN_BITS-1:0]    accum_ff,  accum_in;
   logic [LEN_BITS-1:0]    left_ff,   left_in;
   logic [COUNT_BITS-1:0]  count_ff,  count_in;
   err_type                err_ff,    err_in;

   logic [LEN_CFG_BITS-1:0] lsz;
   logic [SEEN_BITS-1:0]    seen_inc;
   logic [LEN_BITS-1:0]     accum_shift;
   logic [LEN_BITS-1:0]     left_dec;
   logic [STATUS_BITS-1:0]  status;
   logic [31:0]             count_wide;

   assign beat_pop     = beat_valid && (!beat.last_byte || result_space);
   assign result_valid = beat_pop && beat.last_byte;

   always_comb begin
      lsz         = (len_bytes > LEN_BYTES_MAX) ? LEN_BYTES_MAX : len_bytes;
      seen_inc    = seen_ff + 1'b1;
      accum_shift = {accum_ff[LEN_BITS-BYTE_BITS-1:0], beat.data_byte};
      left_dec    = (left_ff != '0) ? left_ff - 1'b1 : left_ff;

      phase_in = phase_ff;
      seen_in  = seen_ff;
      accum_in = accum_ff;
      left_in  = left_ff;
      count_in = count_ff;
      err_in   = err_ff;

      if (err_ff == ERR_NONE) begin
         if (phase_ff == PH_PREFIX) begin
            if (lsz == '0) begin
               err_in = ERR_ZERO;
            end else if (seen_inc >= lsz) begin
               if (accum_shift == '0) begin
                  err_in = ERR_ZERO;
               end else begin
                  left_in  = accum_shift;
                  phase_in = PH_HEADER;
               end
               seen_in  = '0;
               accum_in = '0;
            end else begin
               seen_in  = seen_inc;
               accum_in = accum_shift;
            end
         end else begin
            if (phase_ff == PH_HEADER && nal_type_known(beat.data_byte) &&
                count_ff != COUNT_CAP) begin
               count_in = count_ff + 1'b1;
            end
            left_in  = left_dec;
            phase_in = (left_dec != '0) ? PH_BODY : PH_PREFIX;
         end
      end

      if (lsz == '0) begin
         status = STATUS_ZERO_LEN;
      end else if (err_in == ERR_ZERO) begin
         status = STATUS_ZERO_LEN;
      end else if (err_in == ERR_OVERRUN) begin
         status = STATUS_OVERRUN;
      end else if (phase_in != PH_PREFIX) begin
         status = STATUS_OVERRUN;
      end else if (count_in == '0) begin
         status = STATUS_NO_KNOWN;
      end else if (seen_in != '0) begin
         status = STATUS_TRAILING;
      end else begin
         status = STATUS_OK;
      end

      count_wide         = 32'(count_in);
      result.sample_ok   = (status == STATUS_OK);
      result.status      = status;
      result.known_units = count_wide[KNOWN_OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset || (beat_pop && beat.last_byte)) begin
         phase_ff <= PH_PREFIX;
         seen_ff  <= '0;
         accum_ff <= '0;
         left_ff  <= '0;
         count_ff <= '0;
         err_ff   <= ERR_NONE;
      end else if (beat_pop) begin
         phase_ff <= phase_in;
         seen_ff  <= seen_in;
         accum_ff <= accum_in;
         left_ff  <= left_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

endmodule

@@ rtl/nalv_out_reg.sv @@
`timescale 1ns / 1ps

module nalv_out_reg
   import nalv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  verdict_type load_data,
   output logic        space,
   output logic        out_valid,
   input  logic        out_ready,
   output verdict_type out_data
);

   logic        valid_ff;
   logic        valid_in;
   verdict_type data_ff;

   assign space     = !valid_ff || out_ready;
   assign valid_in  = load || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

@@ rtl/length_prefixed_nal_validator.sv @@
`timescale 1ns / 1ps
// A beat taken on req_ is registered in the input stage, then updates the parser state;
// a last byte's verdict is registered and presented on rsp_. Throughput: one byte beat
// per cycle, limited by the single parser step per cycle, while no last byte waits on a
// full verdict register. Reset: synchronous, active high; clears the parse state and the
// beat and verdict registers, and loads four as the prefix byte count.
module length_prefixed_nal_validator
   import nalv_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [LEN_CFG_BITS-1:0]  csr_data,   // length_field_bytes
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [BYTE_BITS-1:0]     req_tdata,  // data_byte
   input  logic                     req_tlast,  // last_byte
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata   // known_units[15:0], status[2:0], sample_ok
);

   logic [LEN_CFG_BITS-1:0] len_bytes_ff;

   beat_type    req_beat;
   beat_type    s1_beat;
   logic        s1_valid;
   logic        s1_pop;
   logic        out_space;
   logic        verdict_valid;
   verdict_type verdict;
   verdict_type rsp_verdict;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_bytes_ff <= LEN_BYTES_RESET;
      end else if (csr_valid) begin
         len_bytes_ff <= csr_data;
      end
   end

   assign req_beat.data_byte = req_tdata;
   assign req_beat.last_byte = req_tlast;

   nalv_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_beat   (req_beat),
      .out_valid (s1_valid),
      .out_pop   (s1_pop),
      .out_beat  (s1_beat)
   );

   nalv_parser #(
      .COUNT_BITS (COUNT_BITS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .len_bytes    (len_bytes_ff),
      .beat_valid   (s1_valid),
      .beat         (s1_beat),
      .result_space (out_space),
      .beat_pop     (s1_pop),
      .result_valid (verdict_valid),
      .result       (verdict)
   );

   nalv_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (verdict_valid),
      .load_data (verdict),
      .space     (out_space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_verdict)
   );

   assign rsp_tdata = {4'b0000, rsp_verdict};

endmodule

@@ tb/nal_verdict_checker.sv @@
`timescale 1ns / 1ps

module nal_verdict_checker
   import nalv_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [LEN_CFG_BITS-1:0]  csr_data,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [BYTE_BITS-1:0]     req_tdata,   // data_byte
   input  logic                     req_tlast,   // last_byte
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,   // known_units[15:0], status[2:0], sample_ok
   output int                       mismatches,
   output int                       verdicts_owed
);

   typedef enum logic [1:0] {AT_PREFIX, AT_HEADER, IN_BODY} parse_phase_type;

   localparam logic [31:0] COUNT_CAP =
      (COUNT_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << COUNT_BITS) - 64'd1);

   logic [LEN_CFG_BITS-1:0] len_bytes;
   parse_phase_type         phase;
   logic [SEEN_BITS-1:0]    seen;
   logic [LEN_BITS-1:0]     accum;
   logic [LEN_BITS-1:0]     unit_left;
   logic [31:0]             known;
   logic                    zero_fault;
   verdict_type             expected_verdicts[$];
   int                      fail_count = 0;

   function automatic logic is_known_type(input logic [BYTE_BITS-1:0] b);
      case (b[NAL_TYPE_BITS-1:0])
         NAL_SLICE, NAL_IDR, NAL_SEI, NAL_SPS, NAL_PPS, NAL_AUD: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   task automatic clear_sample();
      phase      = AT_PREFIX;
      seen       = '0;
      accum      = '0;
      unit_left  = '0;
      known      = '0;
      zero_fault = 1'b0;
   endtask

   task automatic parse_byte(input logic [BYTE_BITS-1:0] b, input logic last);
      logic [LEN_CFG_BITS-1:0] psize;
      verdict_type             v;
      psize = (len_bytes > LEN_BYTES_MAX) ? LEN_BYTES_MAX : len_bytes;
      if (!zero_fault) begin
         if (phase == AT_PREFIX) begin
            if (psize == 0) begin
               zero_fault = 1'b1;
            end else begin
               accum = {accum[LEN_BITS-BYTE_BITS-1:0], b};
               seen  = seen + 1'b1;
               if (seen >= psize) begin
                  if (accum == 0) begin
                     zero_fault = 1'b1;
                  end else begin
                     unit_left = accum;
                     phase     = AT_HEADER;
                  end
                  seen  = '0;
                  accum = '0;
               end
            end
         end else begin
            if (phase == AT_HEADER && is_known_type(b) && known < COUNT_CAP) known++;
            if (unit_left != 0) unit_left--;
            phase = (unit_left != 0) ? IN_BODY : AT_PREFIX;
         end
      end
      if (last) begin
         if (psize == 0 || zero_fault) v.status = STATUS_ZERO_LEN;
         else if (phase != AT_PREFIX) v.status = STATUS_OVERRUN;
         else if (known == 0)         v.status = STATUS_NO_KNOWN;
         else if (seen != 0)          v.status = STATUS_TRAILING;
         else                         v.status = STATUS_OK;
         v.sample_ok   = (v.status == STATUS_OK);
         v.known_units = known[KNOWN_OUT_BITS-1:0];
         expected_verdicts.push_back(v);
         clear_sample();
      end
   endtask

   always @(posedge clock) begin : watch
      verdict_type got;
      verdict_type want;
      if (reset) begin
         len_bytes = LEN_BYTES_RESET;
         clear_sample();
         expected_verdicts.delete();
      end else begin
         if (csr_valid && csr_ready) len_bytes = csr_data;
         if (req_tvalid && req_tready) parse_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got = verdict_type'(rsp_tdata[$bits(verdict_type)-1:0]);
            if (expected_verdicts.size() == 0) begin
               $error("verdict beat with none expected: rsp_tdata %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (got.sample_ok !== want.sample_ok) begin
                  $error("sample_ok: expected %0d, got %0d", want.sample_ok, got.sample_ok);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.known_units !== want.known_units) begin
                  $error("known_units: expected %0d, got %0d",
                         want.known_units, got.known_units);
                  fail_count++;
               end
            end
         end
      end
      mismatches    <= fail_count;
      verdicts_owed <= expected_verdicts.size();
   end

endmodule

@@ tb/tb_length_prefixed_nal_validator.sv @@
`timescale 1ns / 1ps

module tb_length_prefixed_nal_validator;
   import nalv_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int LONG_HOLD    = 200;
   localparam int RANDOM_BEATS = 1450;
   localparam int PLAN_STEPS   = 9;

   typedef logic [BYTE_BITS-1:0] byte_q_type[$];
   typedef enum int {
      SAMPLE_GOOD, SAMPLE_NO_KNOWN, SAMPLE_ZERO_LEN, SAMPLE_OVERRUN, SAMPLE_TRAILING,
      SAMPLE_NOISE
   } sample_kind_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [LEN_CFG_BITS-1:0]  csr_data   = LEN_BYTES_RESET;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [BYTE_BITS-1:0]     req_tdata  = '0;
   logic                     req_tlast  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   int                      mismatches;
   int                      verdicts_owed;
   int                      cycles     = 0;
   int                      beats_sent = 0;
   int                      hold_reqs  = 0;
   int                      holds_done = 0;
   bit                      quiet      = 1'b0;
   logic [LEN_CFG_BITS-1:0] len_cfg    = LEN_BYTES_RESET;
   byte_q_type              sample_q;

   always #2 clock = ~clock;

   length_prefixed_nal_validator dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   nal_verdict_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .mismatches    (mismatches),
      .verdicts_owed (verdicts_owed)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   // receiver: hold off for long stretches on request, otherwise stall at random
   initial begin
      forever begin
         if (hold_reqs != holds_done) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holds_done++;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_beat(input logic [BYTE_BITS-1:0] b, input logic last);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   task automatic send_sample(input byte_q_type s);
      foreach (s[i]) send_beat(s[i], i == s.size() - 1);
   endtask

   // drain outstanding verdicts and let the parser settle before touching the register
   task automatic write_len_bytes(input logic [LEN_CFG_BITS-1:0] v);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (verdicts_owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      len_cfg = v;
   endtask

   function automatic int prefix_size();
      return (len_cfg > LEN_BYTES_MAX) ? int'(LEN_BYTES_MAX) : int'(len_cfg);
   endfunction

   task automatic push_prefix(input logic [LEN_BITS-1:0] len, input int psize);
      for (int i = psize - 1; i >= 0; i--) sample_q.push_back(8'(len >> (8 * i)));
   endtask

   task automatic push_noise(input int n);
      repeat (n) sample_q.push_back(8'($urandom));
   endtask

   function automatic logic [BYTE_BITS-1:0] header_byte(input bit known);
      logic [NAL_TYPE_BITS-1:0] t;
      int                       r;
      if (known) begin
         case ($urandom_range(0, 5))
            0:       t = NAL_SLICE;
            1:       t = NAL_IDR;
            2:       t = NAL_SEI;
            3:       t = NAL_SPS;
            4:       t = NAL_PPS;
            default: t = NAL_AUD;
         endcase
      end else begin
         r = $urandom_range(0, 25);
         t = (r == 0) ? 5'd0 : (r < 4) ? 5'(r + 1) : 5'(r + 6);
      end
      return {3'($urandom), t};
   endfunction

   function automatic int pick_len(input int psize);
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return $urandom_range(1, 4);
      if (r < 9) return $urandom_range(5, 30);
      return $urandom_range(31, (psize == 1) ? 255 : 400);
   endfunction

   task automatic make_sample();
      sample_kind_type     kind;
      int                  psize;
      int                  units;
      int                  len;
      int                  cut;
      int                  r;
      logic [LEN_BITS-1:0] big_len;
      psize = prefix_size();
      sample_q.delete();
      r = $urandom_range(0, 19);
      kind = (r < 11) ? SAMPLE_GOOD : (r < 13) ? SAMPLE_NO_KNOWN : (r < 15) ? SAMPLE_ZERO_LEN :
             (r < 17) ? SAMPLE_OVERRUN : (r < 19) ? SAMPLE_TRAILING : SAMPLE_NOISE;
      if (psize == 0 || kind == SAMPLE_NOISE) begin
         push_noise($urandom_range(1, 12));
         return;
      end
      if (kind == SAMPLE_TRAILING && psize == 1) kind = SAMPLE_GOOD;
      units = $urandom_range(1, 4);
      for (int u = 0; u < units; u++) begin
         len = (kind == SAMPLE_ZERO_LEN && u == units - 1) ? 0 : pick_len(psize);
         push_prefix(len, psize);
         if (len == 0) begin
            push_noise($urandom_range(0, 3));
            break;
         end
         sample_q.push_back(header_byte(kind != SAMPLE_NO_KNOWN && $urandom_range(0, 3) != 0));
         push_noise(len - 1);
      end
      if (kind == SAMPLE_OVERRUN) begin
         big_len = (psize == 4) ? $urandom_range(7, 32'hFFFF_FFFF)
                                : $urandom_range(7, (1 << (8 * psize)) - 1);
         push_prefix(big_len, psize);
         cut = $urandom_range(0, 6);
         if (cut > 0) begin
            sample_q.push_back(header_byte($urandom_range(0, 1)));
            push_noise(cut - 1);
         end
      end
      if (kind == SAMPLE_TRAILING) push_noise($urandom_range(1, psize - 1));
   endtask

   initial begin : stimulus
      logic [LEN_CFG_BITS-1:0] plan [0:PLAN_STEPS-1];
      int                      phase_start;
      plan = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd5, 3'd7, 3'd6, 3'($urandom_range(0, 7))};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_sample('{8'h00, 8'h00, 8'h00, 8'h01, 8'h65});
      send_sample('{8'h00, 8'h00, 8'h00, 8'h00, 8'hAA});
      write_len_bytes(3'd1);
      send_sample('{8'h02, 8'hE1, 8'hFF, 8'h01, 8'h06, 8'h01, 8'h07, 8'h01, 8'h08,
                    8'h01, 8'h89});
      send_sample('{8'h01, 8'h1F, 8'h03, 8'h00});
      send_sample('{8'h01, 8'h02});
      send_sample('{8'hFF});
      send_sample('{8'h00, 8'h05, 8'h01, 8'h01});
      write_len_bytes(3'd0);
      send_sample('{8'h01, 8'h05});
      write_len_bytes(3'd2);
      send_sample('{8'h00, 8'h01, 8'h07, 8'h00});
      write_len_bytes(3'd7);
      send_sample('{8'h00, 8'h00, 8'h00, 8'h01, 8'h09});

      // change the prefix size part-way through a prefix
      write_len_bytes(3'd4);
      send_beat(8'h00, 1'b0);
      send_beat(8'h00, 1'b0);
      write_len_bytes(3'd2);
      send_sample('{8'h01, 8'h07});

      // keep offering short samples while the receiver holds off
      write_len_bytes(3'd1);
      quiet = 1'b1;
      hold_reqs++;
      repeat (40) send_sample('{8'h01, header_byte($urandom_range(0, 1))});
      quiet = 1'b0;

      for (int p = 0; p < PLAN_STEPS; p++) begin
         write_len_bytes(plan[p]);
         phase_start = beats_sent;
         while (beats_sent - phase_start < RANDOM_BEATS / PLAN_STEPS) begin
            quiet = ($urandom_range(0, 7) == 0);
            make_sample();
            send_sample(sample_q);
         end
      end
      quiet = 1'b0;

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (verdicts_owed != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && verdicts_owed == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/nalv_pkg.sv
rtl/nalv_in_stage.sv
rtl/nalv_parser.sv
rtl/nalv_out_reg.sv
rtl/length_prefixed_nal_validator.sv
tb/nal_verdict_checker.sv
tb/tb_length_prefixed_nal_validator.sv
